// ===== rtl/core/dqd_pkg.sv =====
// Shared types, constants and the exp2 table for the detection query decoder.
package dqd_pkg;

    localparam int CLASS_W  = 7;
    localparam int COORD_W  = 16;
    localparam int DIM_W    = 12;
    localparam int QUOT_W   = 17;
    localparam int DEN_W    = 18;
    localparam int NUMER_W  = 33;
    localparam int CFG_INDEX_W = 3;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] LN2_Q16   = 16'd45426;
    localparam logic [7:0]  EXP_SHIFT_LIMIT = 8'd32;
    localparam logic [NUMER_W-1:0] NUMER_ONE = 33'h1_0000_0000;
    localparam logic [COORD_W-1:0] COORD_MAX = 16'hFFFF;
    localparam logic [15:0] SCORE_MAX = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_MASK_ENABLE     = 3'd1,
        REG_CLASS_MASK_LOW  = 3'd2,
        REG_CLASS_MASK_HIGH = 3'd3,
        REG_SOURCE_WIDTH    = 3'd4,
        REG_SOURCE_HEIGHT   = 3'd5
    } cfg_reg_e;

    typedef logic [CLASS_W-1:0] class_id_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [DIM_W-1:0]   dim_t;

    typedef struct packed {
        logic signed [15:0] best_logit;
        class_id_t          best_class;
        logic               best_found;
        coord_t             center_x;
        coord_t             center_y;
        coord_t             size_x;
        coord_t             size_y;
    } query_t;

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } box_t;

    typedef struct packed {
        logic      neg;
        logic      found;
        class_id_t class_id;
        box_t      box;
    } side_t;

    typedef struct packed {
        logic [NUMER_W-1:0] numer;
        logic [DEN_W-1:0]   denom;
        side_t              side;
    } div_req_t;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        side_t             side;
    } div_res_t;

    // 2^(-k/16) in Q16
    function automatic logic [16:0] exp2_neg_q16(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd62757;
            4'd2:  v = 17'd60097;
            4'd3:  v = 17'd57549;
            4'd4:  v = 17'd55109;
            4'd5:  v = 17'd52773;
            4'd6:  v = 17'd50535;
            4'd7:  v = 17'd48393;
            4'd8:  v = 17'd46341;
            4'd9:  v = 17'd44376;
            4'd10: v = 17'd42495;
            4'd11: v = 17'd40693;
            4'd12: v = 17'd38968;
            4'd13: v = 17'd37316;
            4'd14: v = 17'd35734;
            default: v = 17'd34219;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/dqd_argmax.sv =====
// Running arg-max over allowed class logits; hands a finished query to the decode pipeline.
module dqd_argmax #(
    parameter int MAX_CLASSES = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic signed [15:0]     logit,
    input  dqd_pkg::coord_t        box_center_x,
    input  dqd_pkg::coord_t        box_center_y,
    input  dqd_pkg::coord_t        box_width,
    input  dqd_pkg::coord_t        box_height,
    input  logic                   last_class,
    input  logic                   mask_enable,
    input  logic [127:0]           class_mask,
    output logic                   q_valid,
    output dqd_pkg::query_t        q
);

    localparam int CW = $clog2(MAX_CLASSES);
    localparam logic [CW-1:0] LAST_INDEX = CW'(MAX_CLASSES - 1);

    logic [CW-1:0]        class_counter_reg, class_counter_next;
    logic signed [15:0]   best_logit_reg, best_logit_next;
    dqd_pkg::class_id_t   best_class_reg, best_class_next;
    logic                 best_found_reg, best_found_next;

    dqd_pkg::class_id_t   cls;
    logic                 allowed;
    logic                 take;
    logic signed [15:0]   cand_logit;
    dqd_pkg::class_id_t   cand_class;
    logic                 cand_found;

    always_comb
    begin
        cls        = dqd_pkg::class_id_t'(class_counter_reg);
        allowed    = !mask_enable || class_mask[cls];
        take       = allowed && (!best_found_reg || (logit > best_logit_reg));
        cand_logit = take ? logit : best_logit_reg;
        cand_class = take ? cls : best_class_reg;
        cand_found = best_found_reg || take;

        q_valid         = accept && last_class;
        q.best_logit    = cand_logit;
        q.best_class    = cand_class;
        q.best_found    = cand_found;
        q.center_x      = box_center_x;
        q.center_y      = box_center_y;
        q.size_x        = box_width;
        q.size_y        = box_height;

        class_counter_next = class_counter_reg;
        best_logit_next    = best_logit_reg;
        best_class_next    = best_class_reg;
        best_found_next    = best_found_reg;

        if (accept)
        begin
            if (last_class)
            begin
                // clear for the next query
                class_counter_next = '0;
                best_logit_next    = '0;
                best_class_next    = '0;
                best_found_next    = 1'b0;
            end
            else
            begin
                best_logit_next = cand_logit;
                best_class_next = cand_class;
                best_found_next = cand_found;
                if (class_counter_reg != LAST_INDEX)
                begin
                    class_counter_next = class_counter_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_counter_reg <= '0;
            best_logit_reg    <= '0;
            best_class_reg    <= '0;
            best_found_reg    <= 1'b0;
        end
        else
        begin
            class_counter_reg <= class_counter_next;
            best_logit_reg    <= best_logit_next;
            best_class_reg    <= best_class_next;
            best_found_reg    <= best_found_next;
        end
    end

endmodule

// ===== rtl/core/dqd_front.sv =====
// Exponential and box-scaling pipeline; forms the score division request per query.
module dqd_front #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 q_valid,
    input  dqd_pkg::query_t      q,
    input  dqd_pkg::dim_t        source_width,
    input  dqd_pkg::dim_t        source_height,
    output logic                 req_valid,
    output dqd_pkg::div_req_t    req
);

    localparam int SHIFT = 17 - COORD_FRAC_BITS;
    localparam int ROUND = 1 << (SHIFT - 1);

    // edge = (2*centre -/+ size) times dimension; zero when the edge is not positive
    function automatic logic [29:0] edge_prod(
        input dqd_pkg::coord_t c,
        input dqd_pkg::coord_t s,
        input logic            subtract,
        input dqd_pkg::dim_t   dim
    );
        logic [18:0] twice;
        logic [18:0] sz;
        logic [18:0] d;
        logic [29:0] p;
        twice = {2'b00, c, 1'b0};
        sz    = {3'b000, s};
        d     = subtract ? (twice - sz) : (twice + sz);
        if (d[18] || (d == 19'd0))
        begin
            p = '0;
        end
        else
        begin
            p = {12'b0, d[17:0]} * {18'b0, dim};
        end
        return p;
    endfunction

    function automatic dqd_pkg::coord_t scale_edge(
        input logic [29:0]   prod,
        input dqd_pkg::dim_t dim
    );
        logic [30:0]     sum;
        logic [30:0]     scaled;
        logic [30:0]     lim;
        dqd_pkg::coord_t v;
        sum    = {1'b0, prod} + 31'(ROUND);
        scaled = sum >> SHIFT;
        lim    = {19'b0, dim} << COORD_FRAC_BITS;
        if (scaled > lim)
        begin
            scaled = lim;
        end
        if (scaled > {15'b0, dqd_pkg::COORD_MAX})
        begin
            v = dqd_pkg::COORD_MAX;
        end
        else
        begin
            v = scaled[15:0];
        end
        return v;
    endfunction

    logic [4:0]             valid_reg;

    dqd_pkg::query_t        s1_query_reg;

    logic [31:0]            s2_u_reg;
    logic                   s2_neg_reg;
    logic                   s2_found_reg;
    dqd_pkg::class_id_t     s2_class_reg;
    logic [29:0]            s2_prod_reg [0:3];

    logic [7:0]             s3_n_reg;
    logic [3:0]             s3_k_reg;
    logic [11:0]            s3_t_reg;
    dqd_pkg::side_t         s3_side_reg;

    logic [7:0]             s4_n_reg;
    logic [3:0]             s4_k_reg;
    logic [16:0]            s4_p_reg;
    dqd_pkg::side_t         s4_side_reg;

    logic [7:0]             s5_n_reg;
    logic [16:0]            s5_m_reg;
    dqd_pkg::side_t         s5_side_reg;

    logic [15:0]            best_raw;
    logic [15:0]            abs_logit;
    logic [32:0]            u_full;
    logic [31:0]            u_next;
    logic [29:0]            prod_next [0:3];
    logic [35:0]            t_full;
    logic [11:0]            t_next;
    dqd_pkg::box_t          box_next;
    logic [23:0]            tsq;
    logic [16:0]            p_next;
    logic [33:0]            m_full;
    logic [16:0]            m_next;
    logic [16:0]            e_val;
    logic [17:0]            den;

    always_comb
    begin
        // stage 1: |best| * log2(e), edge products
        best_raw  = s1_query_reg.best_logit;
        abs_logit = best_raw[15] ? (~best_raw + 16'd1) : best_raw;
        u_full    = {17'b0, abs_logit} * {16'b0, dqd_pkg::LOG2E_Q16};
        u_next    = u_full[31:0];
        prod_next[0] = edge_prod(s1_query_reg.center_x, s1_query_reg.size_x, 1'b1,
                                 source_width);
        prod_next[1] = edge_prod(s1_query_reg.center_y, s1_query_reg.size_y, 1'b1,
                                 source_height);
        prod_next[2] = edge_prod(s1_query_reg.center_x, s1_query_reg.size_x, 1'b0,
                                 source_width);
        prod_next[3] = edge_prod(s1_query_reg.center_y, s1_query_reg.size_y, 1'b0,
                                 source_height);

        // stage 2: remainder times ln2, round and clamp edges
        t_full          = {16'b0, s2_u_reg[19:0]} * {20'b0, dqd_pkg::LN2_Q16};
        t_next          = t_full[35:24];
        box_next.left   = scale_edge(s2_prod_reg[0], source_width);
        box_next.top    = scale_edge(s2_prod_reg[1], source_height);
        box_next.right  = scale_edge(s2_prod_reg[2], source_width);
        box_next.bottom = scale_edge(s2_prod_reg[3], source_height);

        // stage 3: second-order polynomial
        tsq    = {12'b0, s3_t_reg} * {12'b0, s3_t_reg};
        p_next = dqd_pkg::ONE_Q16 - {5'b0, s3_t_reg} + {10'b0, tsq[23:17]};

        // stage 4: table scale
        m_full = {17'b0, dqd_pkg::exp2_neg_q16(s4_k_reg)} * {17'b0, s4_p_reg};
        m_next = m_full[32:16];

        // stage 5: integer shift, build dividend and divisor
        e_val = (s5_n_reg >= dqd_pkg::EXP_SHIFT_LIMIT) ? 17'd0 : (s5_m_reg >> s5_n_reg[4:0]);
        den   = {1'b0, dqd_pkg::ONE_Q16} + {1'b0, e_val};
        if (s5_side_reg.neg)
        begin
            req.numer = {e_val, 16'b0} + {16'b0, den[17:1]};
        end
        else
        begin
            req.numer = dqd_pkg::NUMER_ONE + {16'b0, den[17:1]};
        end
        req.denom = den;
        req.side  = s5_side_reg;
    end

    assign req_valid = valid_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[3:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_query_reg <= q;

            s2_u_reg     <= u_next;
            s2_neg_reg   <= s1_query_reg.best_logit[15];
            s2_found_reg <= s1_query_reg.best_found;
            s2_class_reg <= s1_query_reg.best_class;
            for (int i = 0; i < 4; i++)
            begin
                s2_prod_reg[i] <= prod_next[i];
            end

            s3_n_reg             <= s2_u_reg[31:24];
            s3_k_reg             <= s2_u_reg[23:20];
            s3_t_reg             <= t_next;
            s3_side_reg.neg      <= s2_neg_reg;
            s3_side_reg.found    <= s2_found_reg;
            s3_side_reg.class_id <= s2_class_reg;
            s3_side_reg.box      <= box_next;

            s4_n_reg    <= s3_n_reg;
            s4_k_reg    <= s3_k_reg;
            s4_p_reg    <= p_next;
            s4_side_reg <= s3_side_reg;

            s5_n_reg    <= s4_n_reg;
            s5_m_reg    <= m_next;
            s5_side_reg <= s4_side_reg;
        end
    end

endmodule

// ===== rtl/core/dqd_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the rounded score.
module dqd_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 req_valid,
    input  dqd_pkg::div_req_t    req,
    output logic                 res_valid,
    output dqd_pkg::div_res_t    res
);

    localparam int STEPS = dqd_pkg::QUOT_W;
    localparam int DW    = dqd_pkg::DEN_W;
    localparam int NW    = dqd_pkg::NUMER_W;

    logic [STEPS:0]       valid_reg;
    logic [DW-1:0]        rem_reg  [0:STEPS];
    logic [STEPS-1:0]     low_reg  [0:STEPS];
    logic [STEPS-1:0]     quot_reg [0:STEPS];
    logic [DW-1:0]        den_reg  [0:STEPS];
    dqd_pkg::side_t       side_reg [0:STEPS];

    logic [DW:0]          trial     [1:STEPS];
    logic                 ge        [1:STEPS];
    logic [DW-1:0]        rem_next  [1:STEPS];
    logic [STEPS-1:0]     quot_next [1:STEPS];

    always_comb
    begin
        for (int j = 1; j <= STEPS; j++)
        begin
            trial[j]     = {rem_reg[j-1], low_reg[j-1][STEPS-1]};
            ge[j]        = trial[j] >= {1'b0, den_reg[j-1]};
            rem_next[j]  = ge[j] ? DW'(trial[j] - {1'b0, den_reg[j-1]}) : trial[j][DW-1:0];
            quot_next[j] = {quot_reg[j-1][STEPS-2:0], ge[j]};
        end
    end

    assign res_valid = valid_reg[STEPS];
    assign res.quot  = quot_reg[STEPS];
    assign res.side  = side_reg[STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STEPS-1:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= DW'(req.numer[NW-1:STEPS]);
            low_reg[0]  <= req.numer[STEPS-1:0];
            quot_reg[0] <= '0;
            den_reg[0]  <= req.denom;
            side_reg[0] <= req.side;
            for (int j = 1; j <= STEPS; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                low_reg[j]  <= {low_reg[j-1][STEPS-2:0], 1'b0};
                quot_reg[j] <= quot_next[j];
                den_reg[j]  <= den_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

endmodule

// ===== rtl/core/detection_query_decode.sv =====
// Top level: configuration registers, query pipeline and result register.
// One class logit accepted per cycle while in_stall is low; a request carrying last_class
// closes its query, and a new query may close in every cycle that is not stalled.
// Path: four exp/box stages after the one loaded at the accepting edge, the 18-stage
// score divider (load stage plus 17 quotient steps) and the result register.
// Reset restores configuration defaults, clears query state and empties the pipeline.
module detection_query_decode #(
    parameter int MAX_CLASSES     = 128,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [15:0]                logit,
    input  logic [15:0]                       box_center_x,
    input  logic [15:0]                       box_center_y,
    input  logic [15:0]                       box_width,
    input  logic [15:0]                       box_height,
    input  logic                              last_class,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [15:0]                       left,
    output logic [15:0]                       top,
    output logic [15:0]                       right,
    output logic [15:0]                       bottom,
    output logic [15:0]                       score,
    output logic [6:0]                        class_id,
    input  logic                              cfg_write,
    input  logic [dqd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [63:0]                       cfg_data
);

    logic [15:0]            score_threshold_reg;
    logic                   mask_enable_reg;
    logic [63:0]            class_mask_low_reg;
    logic [63:0]            class_mask_high_reg;
    dqd_pkg::dim_t          source_width_reg;
    dqd_pkg::dim_t          source_height_reg;

    logic                   advance;
    logic                   out_ready;
    logic                   q_valid;
    dqd_pkg::query_t        q;
    logic                   req_valid;
    dqd_pkg::div_req_t      req;
    logic                   res_valid;
    dqd_pkg::div_res_t      res;

    logic [15:0]            sat_score;
    logic                   emit;
    logic                   load;
    logic                   out_valid_reg, out_valid_next;
    dqd_pkg::box_t          box_reg;
    logic [15:0]            score_reg;
    dqd_pkg::class_id_t     class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_threshold_reg <= 16'd32768;
            mask_enable_reg     <= 1'b0;
            class_mask_low_reg  <= '0;
            class_mask_high_reg <= '0;
            source_width_reg    <= 12'd1920;
            source_height_reg   <= 12'd1080;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dqd_pkg::REG_SCORE_THRESHOLD: score_threshold_reg <= cfg_data[15:0];
                dqd_pkg::REG_MASK_ENABLE:     mask_enable_reg     <= cfg_data[0];
                dqd_pkg::REG_CLASS_MASK_LOW:  class_mask_low_reg  <= cfg_data;
                dqd_pkg::REG_CLASS_MASK_HIGH: class_mask_high_reg <= cfg_data;
                dqd_pkg::REG_SOURCE_WIDTH:    source_width_reg    <= cfg_data[11:0];
                dqd_pkg::REG_SOURCE_HEIGHT:   source_height_reg   <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    // hold the whole pipeline only when the last divider stage cannot drain
    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = !res_valid || out_ready;
    assign in_stall  = !advance;

    dqd_argmax #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_argmax (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_valid && advance),
        .logit        (logit),
        .box_center_x (box_center_x),
        .box_center_y (box_center_y),
        .box_width    (box_width),
        .box_height   (box_height),
        .last_class   (last_class),
        .mask_enable  (mask_enable_reg),
        .class_mask   ({class_mask_high_reg, class_mask_low_reg}),
        .q_valid      (q_valid),
        .q            (q)
    );

    dqd_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .q_valid       (q_valid),
        .q             (q),
        .source_width  (source_width_reg),
        .source_height (source_height_reg),
        .req_valid     (req_valid),
        .req           (req)
    );

    dqd_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        if (res.quot[16] && !res.side.neg)
        begin
            sat_score = dqd_pkg::SCORE_MAX;
        end
        else
        begin
            sat_score = res.quot[15:0];
        end
        emit = res.side.found && (sat_score >= score_threshold_reg);
        load = out_ready && res_valid && emit;

        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            // drop queries with no allowed class or a score below threshold
            out_valid_next = res_valid && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            box_reg   <= res.side.box;
            score_reg <= sat_score;
            class_reg <= res.side.class_id;
        end
    end

    assign out_valid = out_valid_reg;
    assign left      = box_reg.left;
    assign top       = box_reg.top;
    assign right     = box_reg.right;
    assign bottom    = box_reg.bottom;
    assign score     = score_reg;
    assign class_id  = class_reg;

endmodule

// ===== test/detection_query_decode_tb.sv =====
// Self-checking testbench for detection_query_decode: random requests, bit-exact predictor.
module detection_query_decode_tb;

    localparam int FRAC_BITS = 4;
    localparam int EDGE_SHIFT = 17 - FRAC_BITS;
    localparam int LAST_CLASS_INDEX = 127;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int PRESSURE_ITEMS = 120;
    localparam int REPORT_LINES = 40;
    localparam logic [dqd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [dqd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [16:0] EXP2_NEG [16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773, 17'd50535, 17'd48393,
        17'd46341, 17'd44376, 17'd42495, 17'd40693, 17'd38968, 17'd37316, 17'd35734, 17'd34219
    };

    typedef struct packed {
        logic signed [15:0] logit;
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic [15:0]        bw;
        logic [15:0]        bh;
        logic               last;
    } request_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] score;
        logic [6:0]  class_id;
    } detection_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] logit = '0;
    logic [15:0] box_center_x = '0;
    logic [15:0] box_center_y = '0;
    logic [15:0] box_width = '0;
    logic [15:0] box_height = '0;
    logic last_class = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] score;
    logic [6:0] class_id;
    logic cfg_write = 1'b0;
    logic [dqd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    request_t pending_requests[$];
    detection_t expected_detections[$];
    detection_t next_expected;

    logic [15:0] cfg_threshold = 16'd32768;
    logic cfg_mask_en = 1'b0;
    logic [63:0] cfg_mask_lo = '0;
    logic [63:0] cfg_mask_hi = '0;
    logic [11:0] cfg_width = 12'd1920;
    logic [11:0] cfg_height = 12'd1080;

    int q_count = 0;
    logic signed [15:0] q_best = '0;
    logic [6:0] q_best_class = '0;
    logic q_found = 1'b0;

    int mismatches = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit send_calm = 0;
    bit recv_calm = 0;
    bit press_phase = 0;
    bit press_done = 0;

    detection_query_decode dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .logit        (logit),
        .box_center_x (box_center_x),
        .box_center_y (box_center_y),
        .box_width    (box_width),
        .box_height   (box_height),
        .last_class   (last_class),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left         (left),
        .top          (top),
        .right        (right),
        .bottom       (bottom),
        .score        (score),
        .class_id     (class_id),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] sigmoid_score(input logic signed [15:0] x);
        int xi;
        logic [63:0] a, u, n, frac, r, t, p, m, e, den, s;
        logic [3:0] k;
        xi = x;
        a = (xi < 0) ? 64'(-xi) : 64'(xi);
        u = a * 64'(dqd_pkg::LOG2E_Q16);
        n = u >> 24;
        frac = u & 64'hFF_FFFF;
        k = frac[23:20];
        r = frac & 64'hF_FFFF;
        t = (r * 64'(dqd_pkg::LN2_Q16)) >> 24;
        p = 64'd65536 - t + ((t * t) >> 17);
        m = (64'(EXP2_NEG[k]) * p) >> 16;
        e = (n >= 64'd32) ? 64'd0 : (m >> n);
        den = 64'd65536 + e;
        if (xi >= 0)
        begin
            s = ((64'd1 << 32) + den / 2) / den;
            if (s > 64'd65535)
                s = 64'd65535;
        end
        else
            s = ((e << 16) + den / 2) / den;
        return s[15:0];
    endfunction

    function automatic logic [15:0] edge_px(input longint d, input logic [11:0] dim);
        logic [63:0] lim, v;
        lim = 64'(dim) << FRAC_BITS;
        if (d <= 0)
            return 16'd0;
        v = (64'(d) * 64'(dim) + (64'd1 << (EDGE_SHIFT - 1))) >> EDGE_SHIFT;
        if (v > lim)
            v = lim;
        if (v > 64'd65535)
            v = 64'd65535;
        return v[15:0];
    endfunction

    function automatic bit class_enabled(input int c);
        if (!cfg_mask_en)
            return 1'b1;
        return (c < 64) ? cfg_mask_lo[c] : cfg_mask_hi[c - 64];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] pick_mask();
        case ($urandom_range(0, 3))
            0, 1: return {$urandom, $urandom};
            2: return '1;
            default: return '0;
        endcase
    endfunction

    function automatic logic [11:0] pick_dim();
        case ($urandom_range(0, 3))
            0: return 12'd1;
            1: return 12'd4095;
            default: return 12'($urandom_range(1, 4095));
        endcase
    endfunction

    function automatic request_t rand_request(input logic signed [15:0] lg, input logic last);
        request_t rq;
        rq.logit = lg;
        rq.last = last;
        rq.cx = 16'($urandom);
        rq.cy = 16'($urandom);
        if ($urandom_range(0, 1))
        begin
            rq.bw = 16'($urandom);
            rq.bh = 16'($urandom);
        end
        else
        begin
            rq.bw = 16'($urandom_range(0, 16384));
            rq.bh = 16'($urandom_range(0, 16384));
        end
        return rq;
    endfunction

    task automatic queue_request(input request_t rq);
        pending_requests = {pending_requests, rq};
    endtask

    task automatic offer(input logic signed [15:0] lg, input logic last);
        queue_request(rand_request(lg, last));
    endtask

    task automatic decode_request(input request_t rq);
        detection_t det;
        logic [15:0] s;
        if (class_enabled(q_count) && (!q_found || rq.logit > q_best))
        begin
            q_best = rq.logit;
            q_best_class = 7'(q_count);
            q_found = 1'b1;
        end
        if (!rq.last)
        begin
            if (q_count < LAST_CLASS_INDEX)
                q_count++;
        end
        else
        begin
            s = sigmoid_score(q_best);
            if (q_found && s >= cfg_threshold)
            begin
                det.left = edge_px(2 * longint'(rq.cx) - longint'(rq.bw), cfg_width);
                det.top = edge_px(2 * longint'(rq.cy) - longint'(rq.bh), cfg_height);
                det.right = edge_px(2 * longint'(rq.cx) + longint'(rq.bw), cfg_width);
                det.bottom = edge_px(2 * longint'(rq.cy) + longint'(rq.bh), cfg_height);
                det.score = s;
                det.class_id = q_best_class;
                expected_detections = {expected_detections, det};
            end
            q_count = 0;
            q_best = '0;
            q_best_class = '0;
            q_found = 1'b0;
        end
    endtask

    task automatic push_random_query(input int n);
        logic signed [15:0] lg;
        bit noisy;
        int i;
        lg = '0;
        noisy = ($urandom_range(0, 19) == 0);
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1: lg = 16'($urandom);
                2: ;
                default: lg = 16'($urandom_range(0, 3072) - 1536);
            endcase
            offer(lg, (i == n - 1) || (noisy && $urandom_range(0, 5) == 0));
        end
    endtask

    task automatic write_reg(input logic [dqd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            dqd_pkg::REG_SCORE_THRESHOLD: cfg_threshold = val[15:0];
            dqd_pkg::REG_MASK_ENABLE:     cfg_mask_en = val[0];
            dqd_pkg::REG_CLASS_MASK_LOW:  cfg_mask_lo = val;
            dqd_pkg::REG_CLASS_MASK_HIGH: cfg_mask_hi = val;
            dqd_pkg::REG_SOURCE_WIDTH:    cfg_width = val[11:0];
            dqd_pkg::REG_SOURCE_HEIGHT:   cfg_height = val[11:0];
            default: ;
        endcase
    endtask

    task automatic randomize_config();
        logic [15:0] thr;
        case ($urandom_range(0, 4))
            0: thr = 16'd0;
            1: thr = 16'hFFFF;
            2: thr = 16'($urandom);
            default: thr = 16'($urandom_range(0, 40000));
        endcase
        write_reg(dqd_pkg::REG_SCORE_THRESHOLD, 64'(thr));
        write_reg(dqd_pkg::REG_MASK_ENABLE, 64'($urandom_range(0, 1)));
        write_reg(dqd_pkg::REG_CLASS_MASK_LOW, pick_mask());
        write_reg(dqd_pkg::REG_CLASS_MASK_HIGH, pick_mask());
        write_reg(dqd_pkg::REG_SOURCE_WIDTH, 64'(pick_dim()));
        write_reg(dqd_pkg::REG_SOURCE_HEIGHT, 64'(pick_dim()));
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_detections.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] want, got);
        if (mismatches < REPORT_LINES)
            $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [15:0] want, got);
        if (got !== want)
            report_mismatch(what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_request(pending_requests.pop_front());
                send_gap = send_calm ? 0 : pick_gap();
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    in_valid <= 1'b1;
                    logit <= pending_requests[0].logit;
                    box_center_x <= pending_requests[0].cx;
                    box_center_y <= pending_requests[0].cy;
                    box_width <= pending_requests[0].bw;
                    box_height <= pending_requests[0].bh;
                    last_class <= pending_requests[0].last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_detections.size() == 0)
                report_mismatch("detection with none expected, class_id", 16'd0,
                                {9'd0, class_id});
            else
            begin
                next_expected = expected_detections.pop_front();
                check_field("left", next_expected.left, left);
                check_field("top", next_expected.top, top);
                check_field("right", next_expected.right, right);
                check_field("bottom", next_expected.bottom, bottom);
                check_field("score", next_expected.score, score);
                check_field("class_id", {9'd0, next_expected.class_id}, {9'd0, class_id});
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (press_phase && !press_done)
        begin
            press_done = 1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = recv_calm ? 0 : pick_gap();
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("detection_query_decode verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int ph, n, items, roll, k;
        request_t rq;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_reg(dqd_pkg::REG_SCORE_THRESHOLD, 64'd0);
        @(negedge clk);
        rq = rand_request(16'sh7FFF, 1'b1);
        rq.cx = '1;
        rq.cy = '1;
        rq.bw = '1;
        rq.bh = '1;
        queue_request(rq);
        rq = rand_request(-16'sd32768, 1'b1);
        rq.cx = '0;
        rq.cy = '0;
        rq.bw = '0;
        rq.bh = '0;
        queue_request(rq);
        rq = rand_request(16'sd0, 1'b1);
        rq.cx = 16'h8000;
        rq.cy = 16'h8000;
        rq.bw = 16'h4000;
        rq.bh = 16'h4000;
        queue_request(rq);
        offer(16'sd100, 1'b0);
        offer(16'sd100, 1'b0);
        offer(16'sd50, 1'b1);
        offer(16'sd50, 1'b0);
        offer(16'sd100, 1'b0);
        offer(16'sd100, 1'b1);
        offer(-16'sd5, 1'b0);
        offer(16'sd200, 1'b1);
        offer(-16'sd300, 1'b0);
        offer(-16'sd100, 1'b0);
        offer(-16'sd200, 1'b1);
        settle();

        write_reg(dqd_pkg::REG_MASK_ENABLE, 64'd1);
        write_reg(dqd_pkg::REG_CLASS_MASK_LOW, 64'h2);
        write_reg(dqd_pkg::REG_CLASS_MASK_HIGH, 64'h1);
        @(negedge clk);
        offer(16'sd900, 1'b0);
        offer(16'sd10, 1'b0);
        offer(16'sd20, 1'b1);
        offer(16'sd500, 1'b1);
        settle();

        write_reg(dqd_pkg::REG_MASK_ENABLE, 64'd0);
        write_reg(dqd_pkg::REG_SOURCE_WIDTH, 64'd0);
        write_reg(dqd_pkg::REG_SOURCE_HEIGHT, 64'd0);
        write_reg(dqd_pkg::REG_SCORE_THRESHOLD, 64'hFFFF);
        write_reg(REG_SPARE_A, {$urandom, $urandom});
        write_reg(REG_SPARE_B, {$urandom, $urandom});
        @(negedge clk);
        offer(16'sh7FFF, 1'b1);
        offer(16'sd2000, 1'b1);
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            randomize_config();
            @(negedge clk);
            send_calm = ($urandom_range(0, 4) == 0);
            recv_calm = ($urandom_range(0, 4) == 0);
            items = 0;
            while (items < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    n = $urandom_range(1, 8);
                else if (roll < 90)
                    n = $urandom_range(9, 40);
                else if (roll < 97)
                    n = $urandom_range(60, 128);
                else
                    n = $urandom_range(129, 140);
                push_random_query(n);
                items += n;
            end
            settle();

            if (ph == RANDOM_PHASES / 2)
            begin
                // hold the output while the input keeps coming, so the pipeline backs up
                write_reg(dqd_pkg::REG_MASK_ENABLE, 64'd0);
                write_reg(dqd_pkg::REG_SCORE_THRESHOLD, 64'd0);
                @(negedge clk);
                send_calm = 1;
                recv_calm = 0;
                press_phase = 1;
                for (k = 0; k < PRESSURE_ITEMS; k++)
                    offer(16'($urandom), 1'b1);
                settle();
                press_phase = 0;
                send_calm = 0;
            end
        end

        if (mismatches == 0)
            $display("detection_query_decode verification clean");
        else
            $display("detection_query_decode verification failed");
        $finish;
    end

endmodule
